// ===== src/abe_pkg.sv =====
// Package for the arctangent backbone evaluator: item record, register codes,
// fixed-point constants and elaboration-time builders for the angle and ln(2) constants.
// No dependencies.
package abe_pkg;

	localparam int STRAIN_FRAC_BITS = 28;
	localparam int U_SHIFT          = STRAIN_FRAC_BITS - 12;
	localparam int CORDIC_STEPS     = 62;
	localparam int LOG_BITS         = 56;
	localparam int LOG_STAGES       = 2 * LOG_BITS + 4;
	localparam int Q_BITS           = 48;
	localparam int DIV_STAGES       = Q_BITS + 1;
	localparam int DIV_W            = 144;
	localparam int CFG_IDX_W        = 1;

	localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;
	localparam logic [63:0] ONE_Q63   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] PW_LIMIT  = 64'hFFFF_FFFF_FFFF_FFFF / 64'd9;
	localparam logic [31:0] K1_RESET  = 32'h0001_0000;
	localparam logic [31:0] K2_RESET  = 32'h0001_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_K1_SCALE = 1'b0,
		REG_K2_SLOPE = 1'b1
	} abe_reg_t;

	typedef struct packed {
		logic               k1neg;
		logic               uneg;
		logic               sat;
		logic               k2zero;
		logic               tovf;
		logic               eovf;
		logic [31:0]        k1a;
		logic [31:0]        k2;
		logic [46:0]        ua;
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
		logic [94:0]        w;
		logic [6:0]         lpos;
		logic [62:0]        mt;
		logic [55:0]        f;
		logic [63:0]        lnv;
		logic [5:0][63:0]   pp;
		logic [63:0]        stress_m;
		logic [76:0]        p57;
		logic [DIV_W-1:0]   tnum;
		logic [DIV_W-1:0]   enu;
		logic [94:0]        tden;
		logic [72:0]        eden;
		logic [47:0]        tq;
		logic [47:0]        eq;
	} abe_item_t;

	// shift-subtract divide, used only on constants at elaboration
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic [63:0] series_atan_pow2(input int i);
		logic [63:0] sum;
		logic [63:0] term;
		int k;
		sum = '0;
		k = 0;
		while (i * (2 * k + 1) < 64) begin
			term = udiv64(ONE_Q63 >> (i * (2 * k + 1)), 64'(2 * k + 1));
			if (k[0]) sum = sum - term;
			else      sum = sum + term;
			k++;
		end
		return sum;
	endfunction

	function automatic logic [63:0] atan_third();
		logic [63:0] third;
		logic [63:0] pw;
		logic [63:0] term;
		int k;
		logic done;
		third = '0;
		pw = 64'd3;
		k = 0;
		done = 1'b0;
		while (!done) begin
			term = udiv64(udiv64(ONE_Q63, pw), 64'(2 * k + 1));
			if (k[0]) third = third - term;
			else      third = third + term;
			if (term == '0 || pw > PW_LIMIT) begin
				done = 1'b1;
			end else begin
				pw = pw * 64'd9;
				k++;
			end
		end
		return third;
	endfunction

	// atan(2^-i) in Q.61
	function automatic logic [63:0] atan_entry(input int i);
		if (i == 0) return (series_atan_pow2(1) + atan_third() + 64'd2) >> 2;
		return (series_atan_pow2(i) + 64'd2) >> 2;
	endfunction

	function automatic logic [63:0] ln2_calc();
		logic [63:0] sum;
		sum = '0;
		for (int i = 1; i < 64; i++) begin
			sum = sum + udiv64(ONE_Q63 >> i, 64'(i));
		end
		return sum;
	endfunction

	localparam logic [63:0] LN2_Q63 = ln2_calc();

	// {clipped, value}; value is the signed 48-bit result
	function automatic logic [48:0] sat48(input logic over, input logic [47:0] v,
			input logic neg);
		logic [47:0] lim;
		logic [47:0] m;
		logic        flag;
		lim = neg ? NEG_LIMIT : POS_LIMIT;
		m = v;
		flag = 1'b0;
		if (over || v > lim) begin
			m = lim;
			flag = 1'b1;
		end
		if (neg) m = ~m + 48'd1;
		return {flag, m};
	endfunction

endpackage

// ===== src/abe_in_if.sv =====
// Strain sample channel: valid/ready handshake with one Q3.28 sample per transaction.
// No dependencies.
interface abe_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] strain_in;

	modport source (output valid, output strain_in, input ready);
	modport sink   (input valid, input strain_in, output ready);
endinterface

// ===== src/abe_out_if.sv =====
// Result channel: valid/ready handshake carrying stress, tangent, energy and the clip flag.
// No dependencies.
interface abe_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] stress_out;
	logic signed [47:0] tangent_out;
	logic signed [47:0] energy_out;
	logic               saturated;

	modport source (output valid, output stress_out, output tangent_out,
		output energy_out, output saturated, input ready);
	modport sink   (input valid, input stress_out, input tangent_out,
		input energy_out, input saturated, output ready);
endinterface

// ===== src/abe_front.sv =====
// Front section: magnitudes, scaled strain u with clipping, CORDIC prescale, 1+u*u.
// Depends on abe_pkg.
module abe_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                item_valid,
	input  logic [31:0]         strain,
	input  logic [31:0]         k1_scale,
	input  logic [31:0]         k2_slope,
	output logic                next_valid,
	output abe_pkg::abe_item_t  next_item
);

	logic v_s1, v_s2, v_s3, v_s4;
	abe_pkg::abe_item_t it_s1, it_s2, it_s3, it_s4;
	abe_pkg::abe_item_t d1, d2, d3, d4;

	logic [31:0] sa;
	logic [64:0] ur;
	logic [46:0] m;
	logic [5:0]  tb;
	logic [5:0]  t;

	always_comb begin
		d1 = '0;
		sa = strain[31] ? (~strain + 32'd1) : strain;
		d1.k1neg = k1_scale[31];
		d1.k1a = k1_scale[31] ? (~k1_scale + 32'd1) : k1_scale;
		d1.uneg = strain[31];
		d1.k2 = k2_slope;
		d1.k2zero = (k2_slope == '0);
		d1.pp[0] = 64'(sa) * 64'(k2_slope);
		d1.pp[1] = 64'(d1.k1a) * 64'(k2_slope);
	end

	always_comb begin
		d2 = it_s1;
		ur = {1'b0, it_s1.pp[0]} + (65'd1 << (abe_pkg::U_SHIFT - 1));
		ur = ur >> abe_pkg::U_SHIFT;
		if (ur > 65'(abe_pkg::POS_LIMIT)) begin
			d2.ua = abe_pkg::POS_LIMIT[46:0];
			d2.sat = 1'b1;
		end else begin
			d2.ua = ur[46:0];
		end
		d2.tnum = abe_pkg::DIV_W'({it_s1.pp[1], 40'd0});
	end

	always_comb begin
		d3 = it_s2;
		m = (it_s2.ua > 47'h1000_0000) ? it_s2.ua : 47'h1000_0000;
		tb = '0;
		for (int i = 0; i < 47; i++) begin
			if (m[i]) tb = 6'(i);
		end
		t = 6'd59 - tb;
		d3.x = $signed(64'd1 << (7'd28 + 7'(t)));
		d3.y = $signed(64'(it_s2.ua) << t);
		d3.z = '0;
		d3.pp[0] = 64'(it_s2.ua[23:0]) * 64'(it_s2.ua[23:0]);
		d3.pp[1] = 64'(it_s2.ua[23:0]) * 64'(it_s2.ua[46:24]);
		d3.pp[2] = 64'(it_s2.ua[46:24]) * 64'(it_s2.ua[46:24]);
	end

	always_comb begin
		d4 = it_s3;
		d4.w = (95'(it_s3.pp[2]) << 48) + (95'(it_s3.pp[1]) << 25)
			+ 95'(it_s3.pp[0]) + (95'd1 << 56);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= d1;
			it_s2 <= d2;
			it_s3 <= d3;
			it_s4 <= d4;
		end
	end

	assign next_valid = v_s4;
	assign next_item  = it_s4;

endmodule

// ===== src/abe_cordic.sv =====
// Vectoring CORDIC, one rotation per stage, accumulating atan(|u|) in Q.61.
// Depends on abe_pkg.
module abe_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                item_valid,
	input  abe_pkg::abe_item_t  item,
	output logic                next_valid,
	output abe_pkg::abe_item_t  next_item
);

	localparam int N = abe_pkg::CORDIC_STEPS;

	logic               v_s  [N+1];
	abe_pkg::abe_item_t it_s [N+1];

	assign v_s[0]  = item_valid;
	assign it_s[0] = item;

	for (genvar g = 0; g < N; g++) begin : g_step
		localparam logic [63:0] ANGLE = abe_pkg::atan_entry(g);
		abe_pkg::abe_item_t nx;
		logic signed [63:0] dx, dy;

		assign dx = $signed(it_s[g].y) >>> g;
		assign dy = $signed(it_s[g].x) >>> g;

		always_comb begin
			nx = it_s[g];
			if ($signed(it_s[g].y) > 64'sd0) begin
				nx.x = it_s[g].x + dx;
				nx.y = it_s[g].y - dy;
				nx.z = it_s[g].z + $signed(ANGLE);
			end else begin
				nx.x = it_s[g].x - dx;
				nx.y = it_s[g].y + dy;
				nx.z = it_s[g].z - $signed(ANGLE);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g+1] <= 1'b0;
			else if (en) v_s[g+1] <= v_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) it_s[g+1] <= nx;
		end
	end

	assign next_valid = v_s[N];
	assign next_item  = it_s[N];

endmodule

// ===== src/abe_log.sv =====
// Natural log of 1+u*u in Q.56: normalize, one squaring step per two stages, scale by ln(2).
// Depends on abe_pkg.
module abe_log (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                item_valid,
	input  abe_pkg::abe_item_t  item,
	output logic                next_valid,
	output abe_pkg::abe_item_t  next_item
);

	localparam int N  = abe_pkg::LOG_STAGES;
	localparam int NB = abe_pkg::LOG_BITS;

	logic               v_s  [N+1];
	abe_pkg::abe_item_t it_s [N+1];

	assign v_s[0]  = item_valid;
	assign it_s[0] = item;

	for (genvar g = 0; g < N; g++) begin : g_stage
		abe_pkg::abe_item_t nx;

		if (g == 0) begin : g_enc
			always_comb begin
				nx = it_s[g];
				nx.lpos = '0;
				for (int i = 0; i < 95; i++) begin
					if (it_s[g].w[i]) nx.lpos = 7'(i);
				end
			end
		end else if (g == 1) begin : g_norm
			always_comb begin
				logic [94:0] sh;
				nx = it_s[g];
				if (it_s[g].lpos >= 7'd62) sh = it_s[g].w >> (it_s[g].lpos - 7'd62);
				else                       sh = it_s[g].w << (7'd62 - it_s[g].lpos);
				nx.mt = sh[62:0];
			end
		end else if (g < 2 + 2 * NB) begin : g_sq
			localparam int J  = (g - 2) / 2;
			localparam int PH = (g - 2) % 2;
			if (PH == 0) begin : g_mul
				always_comb begin
					nx = it_s[g];
					nx.pp[0] = 64'(it_s[g].mt[31:0]) * 64'(it_s[g].mt[31:0]);
					nx.pp[1] = 64'(it_s[g].mt[62:32]) * 64'(it_s[g].mt[31:0]);
					nx.pp[2] = 64'(it_s[g].mt[62:32]) * 64'(it_s[g].mt[62:32]);
				end
			end else begin : g_sum
				always_comb begin
					logic [125:0] sq;
					logic [63:0]  s;
					nx = it_s[g];
					sq = (126'(it_s[g].pp[2]) << 64) + (126'(it_s[g].pp[1]) << 33)
						+ 126'(it_s[g].pp[0]);
					s = sq[125:62];
					if (s[63]) begin
						nx.mt = s[63:1];
						nx.f[NB-1-J] = 1'b1;
					end else begin
						nx.mt = s[62:0];
						nx.f[NB-1-J] = 1'b0;
					end
				end
			end
		end else if (g == 2 + 2 * NB) begin : g_lmul
			always_comb begin
				logic [61:0] l2;
				nx = it_s[g];
				l2 = (62'(it_s[g].lpos - 7'd56) << 56) | 62'(it_s[g].f);
				nx.pp[0] = 64'(l2[30:0]) * 64'(abe_pkg::LN2_Q63[31:0]);
				nx.pp[1] = 64'(l2[30:0]) * 64'(abe_pkg::LN2_Q63[63:32]);
				nx.pp[2] = 64'(l2[61:31]) * 64'(abe_pkg::LN2_Q63[31:0]);
				nx.pp[3] = 64'(l2[61:31]) * 64'(abe_pkg::LN2_Q63[63:32]);
			end
		end else begin : g_lsum
			always_comb begin
				logic [126:0] acc;
				nx = it_s[g];
				acc = 127'(it_s[g].pp[0]) + (127'(it_s[g].pp[1]) << 32)
					+ (127'(it_s[g].pp[2]) << 31) + (127'(it_s[g].pp[3]) << 63)
					+ (127'd1 << 62);
				nx.lnv = acc[126:63];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g+1] <= 1'b0;
			else if (en) v_s[g+1] <= v_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) it_s[g+1] <= nx;
		end
	end

	assign next_valid = v_s[N];
	assign next_item  = it_s[N];

endmodule

// ===== src/abe_mix.sv =====
// Product section: stress magnitude, u*atan(u), energy numerator and the two
// division operands. Depends on abe_pkg.
module abe_mix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                item_valid,
	input  abe_pkg::abe_item_t  item,
	output logic                next_valid,
	output abe_pkg::abe_item_t  next_item
);

	localparam int DW = abe_pkg::DIV_W;

	logic v_s1, v_s2, v_s3, v_s4;
	abe_pkg::abe_item_t it_s1, it_s2, it_s3, it_s4;
	abe_pkg::abe_item_t d1, d2, d3, d4;

	logic [61:0]  zc;
	logic [95:0]  ssum;
	logic [109:0] usum;
	logic [76:0]  g;
	logic [109:0] num;

	always_comb begin
		d1 = item;
		zc = item.z[63] ? '0 : item.z[61:0];
		d1.z = $signed(64'(zc));
		d1.pp[0] = 64'(item.k1a) * 64'(zc[30:0]);
		d1.pp[1] = 64'(item.k1a) * 64'(zc[61:31]);
		d1.pp[2] = 64'(item.ua[23:0]) * 64'(zc[30:0]);
		d1.pp[3] = 64'(item.ua[23:0]) * 64'(zc[61:31]);
		d1.pp[4] = 64'(item.ua[46:24]) * 64'(zc[30:0]);
		d1.pp[5] = 64'(item.ua[46:24]) * 64'(zc[61:31]);
	end

	always_comb begin
		d2 = it_s1;
		ssum = (96'(it_s1.pp[1]) << 31) + 96'(it_s1.pp[0]) + (96'd1 << 60);
		d2.stress_m = 64'(ssum >> 61);
		usum = 110'(it_s1.pp[2]) + (110'(it_s1.pp[3]) << 31) + (110'(it_s1.pp[4]) << 24)
			+ (110'(it_s1.pp[5]) << 55) + (110'd1 << 31);
		d2.p57 = usum[108:32];
		d2.tden = it_s1.w;
		d2.tnum = it_s1.tnum + DW'(it_s1.w >> 1);
	end

	always_comb begin
		d3 = it_s2;
		g = (it_s2.p57 >= 77'(it_s2.lnv)) ? (it_s2.p57 - 77'(it_s2.lnv)) : '0;
		d3.p57 = g;
		d3.pp[0] = 64'(g[25:0]) * 64'(it_s2.k1a);
		d3.pp[1] = 64'(g[51:26]) * 64'(it_s2.k1a);
		d3.pp[2] = 64'(g[76:52]) * 64'(it_s2.k1a);
	end

	always_comb begin
		d4 = it_s3;
		num = (110'(it_s3.pp[2]) << 52) + (110'(it_s3.pp[1]) << 26) + 110'(it_s3.pp[0]);
		d4.enu = DW'(num) + (DW'(it_s3.k2) << 40);
		d4.eden = 73'(it_s3.k2) << 41;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= d1;
			it_s2 <= d2;
			it_s3 <= d3;
			it_s4 <= d4;
		end
	end

	assign next_valid = v_s4;
	assign next_item  = it_s4;

endmodule

// ===== src/abe_div.sv =====
// Two restoring dividers side by side (tangent and energy), one quotient bit per
// stage after an overflow check. Depends on abe_pkg.
module abe_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                item_valid,
	input  abe_pkg::abe_item_t  item,
	output logic                next_valid,
	output abe_pkg::abe_item_t  next_item
);

	localparam int N  = abe_pkg::DIV_STAGES;
	localparam int QB = abe_pkg::Q_BITS;
	localparam int DW = abe_pkg::DIV_W;

	logic               v_s  [N+1];
	abe_pkg::abe_item_t it_s [N+1];

	assign v_s[0]  = item_valid;
	assign it_s[0] = item;

	for (genvar g = 0; g < N; g++) begin : g_stage
		abe_pkg::abe_item_t nx;

		if (g == 0) begin : g_ovf
			always_comb begin
				nx = it_s[g];
				nx.tq = '0;
				nx.eq = '0;
				nx.tovf = it_s[g].tnum >= (DW'(it_s[g].tden) << QB);
				nx.eovf = it_s[g].enu >= (DW'(it_s[g].eden) << QB);
			end
		end else begin : g_bit
			localparam int B = QB - g;
			always_comb begin
				logic [DW-1:0] td, ed;
				nx = it_s[g];
				td = DW'(it_s[g].tden) << B;
				ed = DW'(it_s[g].eden) << B;
				if (it_s[g].tnum >= td) begin
					nx.tnum = it_s[g].tnum - td;
					nx.tq[B] = 1'b1;
				end
				if (it_s[g].enu >= ed) begin
					nx.enu = it_s[g].enu - ed;
					nx.eq[B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[g+1] <= 1'b0;
			else if (en) v_s[g+1] <= v_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) it_s[g+1] <= nx;
		end
	end

	assign next_valid = v_s[N];
	assign next_item  = it_s[N];

	a_trem: assert property (@(posedge clk) disable iff (!arst_n)
		(next_valid && !next_item.tovf) |-> (next_item.tnum < DW'(next_item.tden)))
		else $error("tangent remainder not below divisor");

	a_erem: assert property (@(posedge clk) disable iff (!arst_n)
		(next_valid && !next_item.eovf) |-> (next_item.enu < DW'(next_item.eden)))
		else $error("energy remainder not below divisor");

endmodule

// ===== src/arctangent_backbone_eval_unit.sv =====
// Arctangent backbone evaluator, top level. Depends on abe_pkg, abe_in_if, abe_out_if,
// abe_front, abe_cordic, abe_log, abe_mix, abe_div. Stages: front 4, CORDIC 62,
// log 116, products 4, divide 49, output register 1. Throughput: one transaction per
// cycle; the pipeline advances as one and holds only while a result waits at the port.
// Reset: valid bits clear, k1_scale and k2_slope return to 1.0 (65536).
module arctangent_backbone_eval_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [abe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                     cfg_data,
	abe_in_if.sink                          samples,
	abe_out_if.source                       results
);

	logic [31:0] k1_q, k2_q;
	logic        en;
	logic        out_v_q;
	logic [47:0] stress_q, tangent_q, energy_q;
	logic        sat_q;

	logic               fr_v, co_v, lg_v, mx_v, dv_v;
	abe_pkg::abe_item_t fr_it, co_it, lg_it, mx_it, dv_it;

	logic [48:0] rs, rt, re;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q <= abe_pkg::K1_RESET;
			k2_q <= abe_pkg::K2_RESET;
		end else if (cfg_we) begin
			case (abe_pkg::abe_reg_t'(cfg_index))
				abe_pkg::REG_K1_SCALE: k1_q <= cfg_data;
				abe_pkg::REG_K2_SLOPE: k2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en = !out_v_q || results.ready;
	assign samples.ready = en;

	abe_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en),
		.item_valid(samples.valid), .strain(samples.strain_in),
		.k1_scale(k1_q), .k2_slope(k2_q),
		.next_valid(fr_v), .next_item(fr_it)
	);

	abe_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.item_valid(fr_v), .item(fr_it),
		.next_valid(co_v), .next_item(co_it)
	);

	abe_log u_log (
		.clk(clk), .arst_n(arst_n), .en(en),
		.item_valid(co_v), .item(co_it),
		.next_valid(lg_v), .next_item(lg_it)
	);

	abe_mix u_mix (
		.clk(clk), .arst_n(arst_n), .en(en),
		.item_valid(lg_v), .item(lg_it),
		.next_valid(mx_v), .next_item(mx_it)
	);

	abe_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.item_valid(mx_v), .item(mx_it),
		.next_valid(dv_v), .next_item(dv_it)
	);

	always_comb begin
		rs = abe_pkg::sat48(|dv_it.stress_m[63:48], dv_it.stress_m[47:0],
			dv_it.k1neg ^ dv_it.uneg);
		rt = abe_pkg::sat48(dv_it.tovf, dv_it.tq, dv_it.k1neg);
		if (dv_it.k2zero) re = '0;
		else              re = abe_pkg::sat48(dv_it.eovf, dv_it.eq, dv_it.k1neg);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= dv_v;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stress_q  <= rs[47:0];
			tangent_q <= rt[47:0];
			energy_q  <= re[47:0];
			sat_q     <= dv_it.sat | rs[48] | rt[48] | re[48];
		end
	end

	assign results.valid       = out_v_q;
	assign results.stress_out  = $signed(stress_q);
	assign results.tangent_out = $signed(tangent_q);
	assign results.energy_out  = $signed(energy_q);
	assign results.saturated   = sat_q;

	a_k2zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && dv_v && dv_it.k2zero) |=> (results.energy_out == '0))
		else $error("energy nonzero with zero slope");

	a_k1zero: assert property (@(posedge clk) disable iff (!arst_n)
		(en && dv_v && !dv_it.k2zero && dv_it.k1a == '0) |=>
		(results.stress_out == '0 && results.tangent_out == '0 && results.energy_out == '0))
		else $error("nonzero result with zero stress scale");

endmodule
